### sv/dsfc_pkg.sv
// shared types, codes and default parameters of the depth sensor filter
// no dependencies
package dsfc_pkg;

   localparam int FILTER_DEPTH_DEF = 64;
   localparam int CAL_DEPTH_DEF    = 128;
   localparam int CAL_AT_RESET_DEF = 100;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_PRESSURE_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESSURE_BIAS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_BIAS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_WINDOW = 3'd4;

   localparam logic [1:0] ST_SAMPLE    = 2'd0;
   localparam logic [1:0] ST_CAL_OK    = 2'd1;
   localparam logic [1:0] ST_WIN_ZERO  = 2'd2;
   localparam logic [1:0] ST_WIN_LARGE = 2'd3;

   localparam logic [2:0] MS_CAL  = 3'd0;
   localparam logic [2:0] MS_RAWP = 3'd1;
   localparam logic [2:0] MS_RAWD = 3'd2;
   localparam logic [2:0] MS_FILP = 3'd3;
   localparam logic [2:0] MS_FILD = 3'd4;

   localparam logic [2:0] DS_OFF  = 3'd0;
   localparam logic [2:0] DS_PRAW = 3'd1;
   localparam logic [2:0] DS_DRAW = 3'd2;
   localparam logic [2:0] DS_PFIL = 3'd3;
   localparam logic [2:0] DS_DFIL = 3'd4;

   typedef struct packed {
      logic       load;
      logic       cal_cmd;
      logic       ins_start;
      logic       ins_shift;
      logic       ins_place;
      logic       mul_go;
      logic [2:0] mul_sel;
      logic       fin;
      logic [2:0] dest;
      logic       filt_upd;
      logic       div_start;
      logic       push;
   } dsfc_cmd_type;

   typedef struct packed {
      logic is_cmd;
      logic cal_active;
      logic ins_stop;
      logic win_full;
      logic div_busy;
      logic out_free;
   } dsfc_stat_type;

endpackage

### sv/dsfc_if.sv
// request and response channel interfaces of the depth sensor filter
// no dependencies
interface dsfc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] sample_code;
   logic [7:0]  cal_window;
   modport source (output valid, opcode, sample_code, cal_window, input ready);
   modport sink (input valid, opcode, sample_code, cal_window, output ready);
endinterface

interface dsfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] raw_pressure;
   logic [19:0] filtered_pressure;
   logic [15:0] raw_depth;
   logic [15:0] filtered_depth;
   logic        filtered_valid;
   modport source (output valid, status, raw_pressure, filtered_pressure, raw_depth,
                   filtered_depth, filtered_valid, input ready);
   modport sink (input valid, status, raw_pressure, filtered_pressure, raw_depth,
                 filtered_depth, filtered_valid, output ready);
endinterface

### sv/dsfc_ctrl.sv
// controller state machine of the depth sensor filter
// depends on dsfc_pkg
module dsfc_ctrl
   import dsfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dsfc_stat_type stat,
   output dsfc_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_INS    = 4'd2;
   localparam logic [3:0] S_MRD    = 4'd3;
   localparam logic [3:0] S_MMUL   = 4'd4;
   localparam logic [3:0] S_MOFF   = 4'd5;
   localparam logic [3:0] S_FUPD   = 4'd6;
   localparam logic [3:0] S_RPMUL  = 4'd7;
   localparam logic [3:0] S_RPFIN  = 4'd8;
   localparam logic [3:0] S_RDFIN  = 4'd9;
   localparam logic [3:0] S_FPDIV  = 4'd10;
   localparam logic [3:0] S_FPWAIT = 4'd11;
   localparam logic [3:0] S_FDDIV  = 4'd12;
   localparam logic [3:0] S_FDWAIT = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_cmd) begin
               cmd.cal_cmd = 1'b1;
               state_in = S_OUT;
            end else if (stat.cal_active) begin
               cmd.ins_start = 1'b1;
               state_in = S_INS;
            end else begin
               state_in = S_FUPD;
            end
         end
         S_INS: begin
            if (stat.ins_stop) begin
               cmd.ins_place = 1'b1;
               state_in = S_MRD;
            end else begin
               cmd.ins_shift = 1'b1;
            end
         end
         S_MRD: state_in = S_MMUL;
         S_MMUL: begin
            cmd.mul_go = 1'b1;
            cmd.mul_sel = MS_CAL;
            state_in = S_MOFF;
         end
         S_MOFF: begin
            cmd.fin = 1'b1;
            cmd.dest = DS_OFF;
            state_in = S_FUPD;
         end
         S_FUPD: begin
            cmd.filt_upd = 1'b1;
            state_in = S_RPMUL;
         end
         S_RPMUL: begin
            cmd.mul_go = 1'b1;
            cmd.mul_sel = MS_RAWP;
            state_in = S_RPFIN;
         end
         S_RPFIN: begin
            cmd.fin = 1'b1;
            cmd.dest = DS_PRAW;
            cmd.mul_go = 1'b1;
            cmd.mul_sel = MS_RAWD;
            state_in = S_RDFIN;
         end
         S_RDFIN: begin
            cmd.fin = 1'b1;
            cmd.dest = DS_DRAW;
            if (stat.win_full) begin
               cmd.mul_go = 1'b1;
               cmd.mul_sel = MS_FILP;
               state_in = S_FPDIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FPDIV: begin
            cmd.div_start = 1'b1;
            state_in = S_FPWAIT;
         end
         S_FPWAIT: begin
            if (!stat.div_busy) begin
               cmd.fin = 1'b1;
               cmd.dest = DS_PFIL;
               cmd.mul_go = 1'b1;
               cmd.mul_sel = MS_FILD;
               state_in = S_FDDIV;
            end
         end
         S_FDDIV: begin
            cmd.div_start = 1'b1;
            state_in = S_FDWAIT;
         end
         S_FDWAIT: begin
            if (!stat.div_busy) begin
               cmd.fin = 1'b1;
               cmd.dest = DS_DFIL;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/dsfc_dp.sv
// datapath of the depth sensor filter: registers, stores, multiplier, divider
// depends on dsfc_pkg
module dsfc_dp
   import dsfc_pkg::*;
#(
   parameter int FILTER_DEPTH = FILTER_DEPTH_DEF,
   parameter int CAL_DEPTH    = CAL_DEPTH_DEF,
   parameter int CAL_AT_RESET = CAL_AT_RESET_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dsfc_cmd_type          cmd,
   output dsfc_stat_type         stat,
   input  logic                  in_opcode,
   input  logic [15:0]           in_sample_code,
   input  logic [7:0]            in_cal_window,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [19:0]           rsp_raw_pressure,
   output logic [19:0]           rsp_filtered_pressure,
   output logic [15:0]           rsp_raw_depth,
   output logic [15:0]           rsp_filtered_depth,
   output logic                  rsp_filtered_valid
);

   localparam int SB   = SAMPLE_BITS;
   localparam int HW   = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int FFW  = $clog2(FILTER_DEPTH + 1);
   localparam int WW   = FFW;
   localparam int CIW  = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
   localparam int CFW  = $clog2(CAL_DEPTH + 1);
   localparam int SUMW = SB + $clog2(FILTER_DEPTH);
   localparam int PW   = 24 + SUMW;
   localparam int NW   = PW + 1;
   localparam int CNTW = $clog2(NW + 1);
   localparam int QW   = SB + 9;
   localparam int DW   = ((QW + 1) > 32 ? QW + 1 : 32) + 2;
   localparam int CAL_RST = (CAL_AT_RESET < CAL_DEPTH) ? CAL_AT_RESET : CAL_DEPTH;

   localparam logic signed [DW-1:0] OFF_MAX = {{(DW-32){1'b0}}, 32'h7fff_ffff};
   localparam logic signed [DW-1:0] OFF_MIN = {{(DW-32){1'b1}}, 32'h8000_0000};
   localparam logic signed [DW-1:0] P_MAX   = DW'(20'hfffff);
   localparam logic signed [DW-1:0] D_MAX   = DW'(16'hffff);

   // configuration
   logic [23:0] pgain_ff, dgain_ff;
   logic signed [23:0] pbias_ff, dbias_ff;
   logic [6:0]  fwin_ff;

   // item
   logic          op_ff;
   logic [SB-1:0] code_ff;
   logic [7:0]    cw_ff;

   // filter state
   logic [SB-1:0]   ring_mem [FILTER_DEPTH];
   logic [SB-1:0]   ring_rd_ff;
   logic [FFW-1:0]  ffill_ff;
   logic [HW-1:0]   head_ff;
   logic [SUMW-1:0] sum_ff;

   // calibration state
   logic [SB-1:0]  cal_mem [CAL_DEPTH];
   logic [SB-1:0]  cal_rd_ff;
   logic [CFW-1:0] cfill_ff, ctarget_ff, ins_i_ff;
   logic signed [31:0] offset_ff;

   // arithmetic
   logic [PW-1:0]   prod_ff;
   logic [NW-1:0]   quo_ff;
   logic [WW-1:0]   rem_ff;
   logic [CNTW-1:0] cnt_ff;

   // results
   logic [1:0]  res_status_ff;
   logic [19:0] res_praw_ff, res_pfil_ff;
   logic [15:0] res_draw_ff, res_dfil_ff;
   logic        res_fval_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [19:0] rsp_praw_ff, rsp_pfil_ff;
   logic [15:0] rsp_draw_ff, rsp_dfil_ff;
   logic        rsp_fval_ff;

   // window length
   logic [WW-1:0] win;
   always_comb begin
      if (fwin_ff == 7'd0) win = WW'(1);
      else if (32'(fwin_ff) > FILTER_DEPTH) win = WW'(FILTER_DEPTH);
      else win = WW'(fwin_ff);
   end

   // oldest ring entry
   logic [FFW:0] old_t;
   logic [HW-1:0] oldest;
   always_comb begin
      old_t = (FFW+1)'(head_ff) + (FFW+1)'(FILTER_DEPTH) - (FFW+1)'(ffill_ff);
      if (old_t >= (FFW+1)'(FILTER_DEPTH)) old_t = old_t - (FFW+1)'(FILTER_DEPTH);
      oldest = old_t[HW-1:0];
   end

   logic evict;
   assign evict = (FFW+1)'(ffill_ff) >= (FFW+1)'(win);

   // calibration store addressing
   logic [CFW-1:0] cal_ra;
   logic           cal_we;
   logic [SB-1:0]  cal_wd;
   always_comb begin
      if (cmd.ins_start) cal_ra = (cfill_ff != '0) ? cfill_ff - CFW'(1) : '0;
      else if (cmd.ins_shift) cal_ra = (ins_i_ff >= CFW'(2)) ? ins_i_ff - CFW'(2) : '0;
      else cal_ra = cfill_ff >> 1;
      cal_we = cmd.ins_shift | cmd.ins_place;
      cal_wd = cmd.ins_shift ? cal_rd_ff : code_ff;
   end

   always_ff @(posedge clock) begin
      if (cal_we) cal_mem[ins_i_ff[CIW-1:0]] <= cal_wd;
      cal_rd_ff <= cal_mem[cal_ra[CIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.filt_upd) ring_mem[head_ff] <= code_ff;
      ring_rd_ff <= ring_mem[oldest];
   end

   // multiplier
   logic [23:0]   mul_a;
   logic [SUMW-1:0] mul_b;
   logic [PW-1:0] mul_p;
   always_comb begin
      case (cmd.mul_sel)
         MS_CAL: begin
            mul_a = dgain_ff;
            mul_b = SUMW'(cal_rd_ff);
         end
         MS_RAWP: begin
            mul_a = pgain_ff;
            mul_b = SUMW'(code_ff);
         end
         MS_RAWD: begin
            mul_a = dgain_ff;
            mul_b = SUMW'(code_ff);
         end
         MS_FILP: begin
            mul_a = pgain_ff;
            mul_b = sum_ff;
         end
         MS_FILD: begin
            mul_a = dgain_ff;
            mul_b = sum_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // restoring divider step
   logic [WW:0] dv_sh;
   logic        dv_take;
   assign dv_sh   = {rem_ff, quo_ff[NW-1]};
   assign dv_take = dv_sh >= (WW+1)'(win);

   // finishing map
   logic [NW-1:0]       rnd;
   logic [QW-1:0]       q_sel;
   logic signed [23:0]  bias_sel;
   logic signed [DW-1:0] lin_x, neg_x, dsum, off_ext;
   logic signed [31:0]  off_sat;
   logic [19:0]         p_clamp;
   logic [15:0]         d_clamp;
   always_comb begin
      rnd = NW'(prod_ff) + NW'(32'h8000);
      if (cmd.dest == DS_PFIL || cmd.dest == DS_DFIL) q_sel = quo_ff[16 +: QW];
      else q_sel = rnd[16 +: QW];
      if (cmd.dest == DS_PRAW || cmd.dest == DS_PFIL) bias_sel = pbias_ff;
      else bias_sel = dbias_ff;
      lin_x = $signed({{(DW-QW){1'b0}}, q_sel}) + $signed({{(DW-24){bias_sel[23]}}, bias_sel});
      neg_x = -lin_x;
      if (neg_x > OFF_MAX) off_sat = 32'sh7fff_ffff;
      else if (neg_x < OFF_MIN) off_sat = 32'sh8000_0000;
      else off_sat = neg_x[31:0];
      off_ext = $signed({{(DW-32){offset_ff[31]}}, offset_ff});
      dsum = lin_x + off_ext;
      if (lin_x[DW-1]) p_clamp = '0;
      else if (lin_x > P_MAX) p_clamp = 20'hfffff;
      else p_clamp = lin_x[19:0];
      if (dsum[DW-1]) d_clamp = '0;
      else if (dsum > D_MAX) d_clamp = 16'hffff;
      else d_clamp = dsum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pgain_ff <= 24'd250000;
         pbias_ff <= 24'sd10000;
         dgain_ff <= 24'd25974;
         dbias_ff <= -24'sd9488;
         fwin_ff  <= 7'd50;
         ffill_ff <= '0;
         head_ff  <= '0;
         sum_ff   <= '0;
         cfill_ff <= '0;
         ctarget_ff <= CFW'(CAL_RST);
         offset_ff <= '0;
         cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PRESSURE_GAIN: pgain_ff <= csr_data;
               REG_PRESSURE_BIAS: pbias_ff <= csr_data;
               REG_DEPTH_GAIN:    dgain_ff <= csr_data;
               REG_DEPTH_BIAS:    dbias_ff <= csr_data;
               REG_FILTER_WINDOW: begin
                  fwin_ff  <= csr_data[6:0];
                  ffill_ff <= '0;
                  head_ff  <= '0;
                  sum_ff   <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.cal_cmd && cw_ff != 8'd0 && 32'(cw_ff) <= CAL_DEPTH) begin
            ctarget_ff <= CFW'(cw_ff);
            cfill_ff   <= '0;
         end
         if (cmd.ins_place) cfill_ff <= cfill_ff + CFW'(1);
         if (cmd.fin && cmd.dest == DS_OFF) offset_ff <= off_sat;
         if (cmd.filt_upd) begin
            sum_ff <= sum_ff - (evict ? SUMW'(ring_rd_ff) : '0) + SUMW'(code_ff);
            if (!evict) ffill_ff <= ffill_ff + FFW'(1);
            head_ff <= (32'(head_ff) == FILTER_DEPTH - 1) ? '0 : head_ff + HW'(1);
         end
         if (cmd.div_start) cnt_ff <= CNTW'(NW);
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - CNTW'(1);
         if (cmd.push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_opcode;
         code_ff <= SB'(in_sample_code);
         cw_ff   <= in_cal_window;
         res_status_ff <= ST_SAMPLE;
         res_praw_ff <= '0;
         res_pfil_ff <= '0;
         res_draw_ff <= '0;
         res_dfil_ff <= '0;
         res_fval_ff <= 1'b0;
      end
      if (cmd.cal_cmd) begin
         if (cw_ff == 8'd0) res_status_ff <= ST_WIN_ZERO;
         else if (32'(cw_ff) > CAL_DEPTH) res_status_ff <= ST_WIN_LARGE;
         else res_status_ff <= ST_CAL_OK;
      end
      if (cmd.ins_start) ins_i_ff <= cfill_ff;
      else if (cmd.ins_shift) ins_i_ff <= ins_i_ff - CFW'(1);
      if (cmd.mul_go) prod_ff <= mul_p;
      if (cmd.div_start) begin
         quo_ff <= NW'(prod_ff) + (NW'(win) << 15);
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NW-2:0], dv_take};
         rem_ff <= dv_take ? WW'(dv_sh - (WW+1)'(win)) : dv_sh[WW-1:0];
      end
      if (cmd.fin) begin
         case (cmd.dest)
            DS_PRAW: res_praw_ff <= p_clamp;
            DS_DRAW: res_draw_ff <= d_clamp;
            DS_PFIL: res_pfil_ff <= p_clamp;
            DS_DFIL: begin
               res_dfil_ff <= d_clamp;
               res_fval_ff <= 1'b1;
            end
            default: ;
         endcase
      end
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_praw_ff   <= res_praw_ff;
         rsp_pfil_ff   <= res_pfil_ff;
         rsp_draw_ff   <= res_draw_ff;
         rsp_dfil_ff   <= res_dfil_ff;
         rsp_fval_ff   <= res_fval_ff;
      end
   end

   assign stat.is_cmd     = op_ff;
   assign stat.cal_active = cfill_ff < ctarget_ff;
   assign stat.ins_stop   = (ins_i_ff == '0) || !(cal_rd_ff > code_ff);
   assign stat.win_full   = (FFW+1)'(ffill_ff) == (FFW+1)'(win);
   assign stat.div_busy   = cnt_ff != '0;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_raw_pressure      = rsp_praw_ff;
   assign rsp_filtered_pressure = rsp_pfil_ff;
   assign rsp_raw_depth         = rsp_draw_ff;
   assign rsp_filtered_depth    = rsp_dfil_ff;
   assign rsp_filtered_valid    = rsp_fval_ff;

endmodule

### sv/depth_sensor_filter_calibrate_top.sv
// top level of the depth sensor filter with zero-depth calibration
// depends on dsfc_pkg, dsfc_if, dsfc_ctrl, dsfc_dp
//
//   channel   dir  transfer when          payload
//   req_bus   in   valid & ready          opcode, sample_code, cal_window
//   rsp_bus   out  valid & ready          status, pressures, depths, filtered_valid
//   csr_*     in   csr_we                 csr_index, csr_data
//
// while calibrating, a sample is placed in the sorted calibration store by shifting
// up to CAL_DEPTH - 1 entries; once the window is full, the filtered pressure and
// filtered depth each take a serial divide by the window length
// reset is synchronous, clears control state and loads the configuration defaults; the stores need no clear
// one result register: a new request is taken while the last result waits
module depth_sensor_filter_calibrate_top
   import dsfc_pkg::*;
#(
   parameter int FILTER_DEPTH = FILTER_DEPTH_DEF,
   parameter int CAL_DEPTH    = CAL_DEPTH_DEF,
   parameter int CAL_AT_RESET = CAL_AT_RESET_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dsfc_req_if.sink              req_bus,
   dsfc_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dsfc_cmd_type  cmd;
   dsfc_stat_type stat;

   dsfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsfc_dp #(
      .FILTER_DEPTH (FILTER_DEPTH),
      .CAL_DEPTH    (CAL_DEPTH),
      .CAL_AT_RESET (CAL_AT_RESET),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .in_opcode             (req_bus.opcode),
      .in_sample_code        (req_bus.sample_code),
      .in_cal_window         (req_bus.cal_window),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_ready             (rsp_bus.ready),
      .rsp_valid             (rsp_bus.valid),
      .rsp_status            (rsp_bus.status),
      .rsp_raw_pressure      (rsp_bus.raw_pressure),
      .rsp_filtered_pressure (rsp_bus.filtered_pressure),
      .rsp_raw_depth         (rsp_bus.raw_depth),
      .rsp_filtered_depth    (rsp_bus.filtered_depth),
      .rsp_filtered_valid    (rsp_bus.filtered_valid)
   );

endmodule

### verif/depth_sensor_filter_calibrate_top_tb.sv
// self-checking testbench for depth_sensor_filter_calibrate_top: filter, calibration and maps
// depends on dsfc_pkg, dsfc_if and the block's rtl
`timescale 1ns / 100ps

module depth_sensor_filter_calibrate_top_tb;
   import dsfc_pkg::*;

   localparam bit OP_SAMPLE = 1'b0;
   localparam bit OP_RECAL  = 1'b1;
   localparam int FDEPTH    = FILTER_DEPTH_DEF;
   localparam int CDEPTH    = CAL_DEPTH_DEF;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct packed {
      bit        opcode;
      bit [15:0] code;
      bit [7:0]  cal_window;
   } depth_req_t;

   typedef struct packed {
      bit [1:0]  status;
      bit [19:0] raw_p;
      bit [19:0] filt_p;
      bit [15:0] raw_d;
      bit [15:0] filt_d;
      bit        filt_valid;
   } depth_rsp_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   dsfc_req_if req_bus ();
   dsfc_rsp_if rsp_bus ();

   depth_sensor_filter_calibrate_top DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   longint unsigned p_gain, d_gain, win_reg;
   longint p_bias, d_bias, zero_offset;
   bit [15:0] win_ring [FDEPTH];
   bit [15:0] cal_sorted [CDEPTH];
   int unsigned win_fill, win_head, cal_count, cal_goal;
   longint unsigned win_sum;

   depth_req_t pending_reqs[$];
   depth_rsp_t expected_rsps[$];
   int errors;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint lin_map(longint unsigned gain, longint unsigned num,
                                      longint unsigned den, longint bias);
      longint unsigned q;
      q = (gain * num + (den << 15)) / (den << 16);
      return longint'(q) + bias;
   endfunction

   function automatic longint sat(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_reset();
      p_gain = 250000; p_bias = 10000; d_gain = 25974; d_bias = -9488; win_reg = 50;
      win_fill = 0; win_head = 0; win_sum = 0;
      cal_count = 0; cal_goal = (CAL_AT_RESET_DEF < CDEPTH) ? CAL_AT_RESET_DEF : CDEPTH;
      zero_offset = 0;
   endtask

   function automatic depth_rsp_t predict_depth(depth_req_t r);
      depth_rsp_t o;
      int unsigned w, i, oldest;
      longint off;
      o = '0;
      if (r.opcode == OP_RECAL) begin
         if (r.cal_window == 0) o.status = ST_WIN_ZERO;
         else if (r.cal_window > CDEPTH) o.status = ST_WIN_LARGE;
         else begin
            cal_goal = 32'(r.cal_window);
            cal_count = 0;
            o.status = ST_CAL_OK;
         end
         return o;
      end
      if (cal_count < cal_goal && cal_count < CDEPTH) begin
         i = cal_count;
         while (i > 0 && cal_sorted[i-1] > r.code) begin
            cal_sorted[i] = cal_sorted[i-1];
            i--;
         end
         cal_sorted[i] = r.code;
         cal_count++;
         off = -lin_map(d_gain, cal_sorted[cal_count/2], 1, d_bias);
         if (off > 64'sd2147483647) off = 64'sd2147483647;
         if (off < -64'sd2147483648) off = -64'sd2147483648;
         zero_offset = off;
      end
      w = (win_reg < 1) ? 1 : (win_reg > FDEPTH) ? FDEPTH : int'(win_reg);
      if (win_fill >= w) begin
         oldest = (win_head + FDEPTH - (win_fill % FDEPTH)) % FDEPTH;
         win_sum -= win_ring[oldest];
         win_fill--;
      end
      win_ring[win_head] = r.code;
      win_head = (win_head + 1) % FDEPTH;
      win_sum += r.code;
      win_fill++;
      o.status = ST_SAMPLE;
      o.raw_p = 20'(sat(lin_map(p_gain, r.code, 1, p_bias), 1048575));
      o.raw_d = 16'(sat(lin_map(d_gain, r.code, 1, d_bias) + zero_offset, 65535));
      if (win_fill == w) begin
         o.filt_p = 20'(sat(lin_map(p_gain, win_sum, w, p_bias), 1048575));
         o.filt_d = 16'(sat(lin_map(d_gain, win_sum, w, d_bias) + zero_offset, 65535));
         o.filt_valid = 1'b1;
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic bit pause_now();
      // long quiet stretch with no idling
      if (cycles % 40000 < 8000) return 1'b0;
      return $urandom_range(99) < 24;
   endfunction

   // request driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            depth_rsp_t pr;
            pr = predict_depth({req_bus.opcode, req_bus.sample_code, req_bus.cal_window});
            expected_rsps = {expected_rsps, pr};
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() > 0 && !pause_now()) begin
               depth_req_t r;
               r = pending_reqs[0];
               pending_reqs.delete(0);
               req_bus.valid <= 1'b1;
               req_bus.opcode <= r.opcode;
               req_bus.sample_code <= r.code;
               req_bus.cal_window <= r.cal_window;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transfer status", rsp_bus.status, -1);
            end else begin
               depth_rsp_t e;
               e = expected_rsps[0];
               expected_rsps.delete(0);
               if (rsp_bus.status !== e.status)
                  report_mismatch("status", rsp_bus.status, e.status);
               if (rsp_bus.raw_pressure !== e.raw_p)
                  report_mismatch("raw_pressure", rsp_bus.raw_pressure, e.raw_p);
               if (rsp_bus.filtered_pressure !== e.filt_p)
                  report_mismatch("filtered_pressure", rsp_bus.filtered_pressure, e.filt_p);
               if (rsp_bus.raw_depth !== e.raw_d)
                  report_mismatch("raw_depth", rsp_bus.raw_depth, e.raw_d);
               if (rsp_bus.filtered_depth !== e.filt_d)
                  report_mismatch("filtered_depth", rsp_bus.filtered_depth, e.filt_d);
               if (rsp_bus.filtered_valid !== e.filt_valid)
                  report_mismatch("filtered_valid", rsp_bus.filtered_valid, e.filt_valid);
            end
         end
         rsp_bus.ready <= !pause_now();
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         REG_PRESSURE_GAIN: p_gain = 64'(val);
         REG_PRESSURE_BIAS: p_bias = longint'($signed(val));
         REG_DEPTH_GAIN:    d_gain = 64'(val);
         REG_DEPTH_BIAS:    d_bias = longint'($signed(val));
         REG_FILTER_WINDOW: begin
            win_reg = 64'(val[6:0]);
            win_fill = 0; win_head = 0; win_sum = 0;
         end
         default: ;
      endcase
   endtask

   task automatic write_all(logic [23:0] pg, logic [23:0] pb, logic [23:0] dg,
                            logic [23:0] db, logic [6:0] w);
      write_reg(REG_PRESSURE_GAIN, pg);
      write_reg(REG_PRESSURE_BIAS, pb);
      write_reg(REG_DEPTH_GAIN, dg);
      write_reg(REG_DEPTH_BIAS, db);
      write_reg(REG_FILTER_WINDOW, {17'd0, w});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_req(bit op, bit [15:0] code, bit [7:0] cw);
      depth_req_t r;
      r.opcode = op; r.code = code; r.cal_window = cw;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() > 0 || req_bus.valid || expected_rsps.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_reg24();
      case ($urandom_range(5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'h7FFFFF;
         3: return 24'h800000;
         4: return 24'($urandom_range(300000));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_items(int n);
      bit [15:0] level;
      level = 16'($urandom);
      repeat (n) begin
         if ($urandom_range(99) < 7) begin
            case ($urandom_range(9))
               0: add_req(OP_RECAL, 16'($urandom), 8'd0);
               1: add_req(OP_RECAL, 16'($urandom), 8'($urandom_range(255, CDEPTH + 1)));
               2: add_req(OP_RECAL, 16'($urandom), 8'd128);
               default: add_req(OP_RECAL, 16'($urandom), 8'($urandom_range(12, 1)));
            endcase
         end else begin
            case ($urandom_range(9))
               0: add_req(OP_SAMPLE, 16'($urandom), 8'($urandom));
               1: add_req(OP_SAMPLE, $urandom_range(1) ? 16'hFFFF : 16'h0000, 8'($urandom));
               default: begin
                  level = level + 16'($urandom_range(400)) - 16'd200;
                  add_req(OP_SAMPLE, level, 8'($urandom));
               end
            endcase
         end
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_SAMPLE;
      req_bus.sample_code = '0;
      req_bus.cal_window = '0;
      rsp_bus.ready = 1'b0;
      predict_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, command codes, field extremes
      add_req(OP_SAMPLE, 16'h0000, 8'hFF);
      add_req(OP_SAMPLE, 16'hFFFF, 8'h00);
      add_req(OP_RECAL, 16'hFFFF, 8'd0);
      add_req(OP_RECAL, 16'h0000, 8'd129);
      add_req(OP_RECAL, 16'h0000, 8'd255);
      add_req(OP_RECAL, 16'h0000, 8'd3);
      add_req(OP_SAMPLE, 16'd30000, 8'd0);
      add_req(OP_SAMPLE, 16'd100, 8'd0);
      add_req(OP_SAMPLE, 16'd65000, 8'd0);
      add_req(OP_SAMPLE, 16'd5, 8'd0);
      add_req(OP_RECAL, 16'h0000, 8'd128);
      add_req(OP_SAMPLE, 16'h1234, 8'd0);
      drain();

      // window of one, saturating gains and biases
      write_all(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h800000, 7'd1);
      add_req(OP_RECAL, 16'h0, 8'd1);
      add_req(OP_SAMPLE, 16'hFFFF, 8'd0);
      add_req(OP_SAMPLE, 16'h0000, 8'd0);
      add_req(OP_SAMPLE, 16'h8000, 8'd0);
      drain();

      // window zero acts as one, window above depth acts as depth
      write_all(24'h000000, 24'h800000, 24'h000000, 24'h7FFFFF, 7'd0);
      add_req(OP_SAMPLE, 16'h0001, 8'd0);
      add_req(OP_SAMPLE, 16'hFFFE, 8'd0);
      drain();
      write_all(24'd250000, 24'd10000, 24'd25974, -24'sd9488, 7'd127);
      random_items(80);
      drain();

      repeat (7) begin
         case ($urandom_range(3))
            0: write_all(rand_reg24(), rand_reg24(), rand_reg24(), rand_reg24(),
                         7'($urandom_range(8, 1)));
            1: write_all(rand_reg24(), rand_reg24(), rand_reg24(), rand_reg24(), 7'd64);
            2: write_all(24'($urandom_range(400000)), 24'($urandom_range(20000)),
                         24'($urandom_range(40000)), -24'sd9488, 7'($urandom));
            default: write_all(rand_reg24(), rand_reg24(), rand_reg24(), rand_reg24(),
                               7'($urandom_range(64, 1)));
         endcase
         random_items(45);
         drain();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/dsfc_pkg.sv
sv/dsfc_if.sv
sv/dsfc_ctrl.sv
sv/dsfc_dp.sv
sv/depth_sensor_filter_calibrate_top.sv
verif/depth_sensor_filter_calibrate_top_tb.sv
